### design/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and constants for the sorted key list.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int KEY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // RAM write selection
  typedef enum logic [1:0] {
    W_KEY_UP    = 2'd0,  // key at idx+1
    W_DATA_UP   = 2'd1,  // read data at idx+1
    W_KEY_AT    = 2'd2,  // key at idx
    W_DATA_DOWN = 2'd3   // read data at idx-1
  } wsel_t;

  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_IDX  = 2'd1,
    POS_IDX1 = 2'd2
  } pos_sel_t;

  typedef struct packed {
    logic     start;
    logic     start_top;  // index starts at the last entry
    logic     idx_inc;
    logic     idx_dec;
    logic     ram_we;
    wsel_t    wsel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     res_set;
    status_t  res_st;
    logic     res_hit;
    pos_sel_t pos_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;        // read data equals key
    logic gt;        // read data above key, signed
    logic idx_zero;
    logic idx_last;  // index is count-1
    logic cnt_zero;
    logic cnt_full;
    logic out_free;
  } dp_stat_t;

endpackage

### design/skl_ram.sv
// ----------------------------------------------------------------------------
// skl_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skl_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/skl_ctrl.sv
// ----------------------------------------------------------------------------
// skl_ctrl
// Command sequencer: scans and shifts the list one entry per step.
// ----------------------------------------------------------------------------
module skl_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [skl_pkg::CMD_W-1:0] in_command,
  input  skl_pkg::dp_stat_t        stat,
  output skl_pkg::dp_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_SREAD = 7'b0010000,
    S_SEVAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [skl_pkg::CMD_W-1:0]   op_r, op_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_command;
          case (in_command)
            skl_pkg::CMD_INSERT: begin
              if (stat.cnt_full) begin
                cmd.res_set = 1'b1;
                cmd.res_st  = skl_pkg::ST_FULL;
                state_nxt   = S_DONE;
              end else begin
                cmd.start     = 1'b1;
                cmd.start_top = ~stat.cnt_zero;
                state_nxt     = stat.cnt_zero ? S_PUT : S_READ;
              end
            end
            skl_pkg::CMD_REMOVE, skl_pkg::CMD_SEARCH: begin
              if (stat.cnt_zero) begin
                cmd.res_set = 1'b1;
                cmd.res_st  = (in_command == skl_pkg::CMD_REMOVE) ?
                              skl_pkg::ST_EMPTY : skl_pkg::ST_MISSING;
                state_nxt   = S_DONE;
              end else begin
                cmd.start = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              cmd.cnt_clr = 1'b1;
              cmd.res_set = 1'b1;
              cmd.res_st  = skl_pkg::ST_OK;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (op_r == skl_pkg::CMD_INSERT) begin
          if (stat.gt) begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = skl_pkg::W_DATA_UP;
            if (stat.idx_zero) begin
              state_nxt = S_PUT;
            end else begin
              cmd.idx_dec = 1'b1;
              state_nxt   = S_READ;
            end
          end else begin
            cmd.ram_we  = 1'b1;
            cmd.wsel    = skl_pkg::W_KEY_UP;
            cmd.cnt_inc = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_st  = skl_pkg::ST_OK;
            cmd.res_hit = 1'b1;
            cmd.pos_sel = skl_pkg::POS_IDX1;
            state_nxt   = S_DONE;
          end
        end else if (stat.eq) begin
          cmd.res_set = 1'b1;
          cmd.res_st  = skl_pkg::ST_OK;
          cmd.res_hit = 1'b1;
          cmd.pos_sel = skl_pkg::POS_IDX;
          if (op_r == skl_pkg::CMD_SEARCH) begin
            state_nxt = S_DONE;
          end else if (stat.idx_last) begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SREAD;
          end
        end else if (stat.gt || stat.idx_last) begin
          cmd.res_set = 1'b1;
          cmd.res_st  = skl_pkg::ST_MISSING;
          state_nxt   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_PUT: begin
        cmd.ram_we  = 1'b1;
        cmd.wsel    = skl_pkg::W_KEY_AT;
        cmd.cnt_inc = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_st  = skl_pkg::ST_OK;
        cmd.res_hit = 1'b1;
        cmd.pos_sel = skl_pkg::POS_IDX;
        state_nxt   = S_DONE;
      end
      S_SREAD: state_nxt = S_SEVAL;
      S_SEVAL: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = skl_pkg::W_DATA_DOWN;
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SREAD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

### design/skl_dp.sv
// ----------------------------------------------------------------------------
// skl_dp
// Datapath: key store, scan index, count, result and output register.
// ----------------------------------------------------------------------------
module skl_dp #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [skl_pkg::KEY_W-1:0]   in_key,
  input  skl_pkg::dp_cmd_t                   cmd,
  output skl_pkg::dp_stat_t                  stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [skl_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_found,
  output logic [skl_pkg::POS_W-1:0]          out_position,
  output logic [skl_pkg::CNT_W-1:0]          out_entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [skl_pkg::KEY_W-1:0] key_r;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [skl_pkg::KEY_W-1:0] rdata;
  logic                      we;
  logic [IW-1:0]             waddr;
  logic [skl_pkg::KEY_W-1:0] wdata;
  skl_pkg::status_t          res_st_r;
  logic                      res_hit_r;
  logic [IW-1:0]             res_pos_r;
  logic                      out_valid_r;
  logic [skl_pkg::STATUS_W-1:0] out_status_r;
  logic                      out_found_r;
  logic [skl_pkg::POS_W-1:0] out_pos_r;
  logic [skl_pkg::CNT_W-1:0] out_cnt_r;

  assign stat.eq       = (rdata == key_r);
  assign stat.gt       = ($signed(rdata) > $signed(key_r));
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign stat.cnt_zero = (count_r == '0);
  assign stat.cnt_full = (count_r == CW'(DEPTH));
  assign stat.out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    we    = cmd.ram_we;
    waddr = idx_r;
    wdata = key_r;
    case (cmd.wsel)
      skl_pkg::W_KEY_UP:    waddr = IW'(idx_r + IW'(1));
      skl_pkg::W_DATA_UP: begin
        waddr = IW'(idx_r + IW'(1));
        wdata = rdata;
      end
      skl_pkg::W_KEY_AT:    waddr = idx_r;
      skl_pkg::W_DATA_DOWN: begin
        waddr = IW'(idx_r - IW'(1));
        wdata = rdata;
      end
      default: waddr = idx_r;
    endcase
  end

  skl_ram #(.W(skl_pkg::KEY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = cmd.start_top ? IW'(count_r - CW'(1)) : '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IW'(idx_r + IW'(1));
    end else if (cmd.idx_dec) begin
      idx_nxt = IW'(idx_r - IW'(1));
    end
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = CW'(count_r + CW'(1));
    end else if (cmd.cnt_dec) begin
      count_nxt = CW'(count_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r <= idx_nxt;
    if (cmd.start) begin
      key_r <= in_key;
    end
    if (cmd.res_set) begin
      res_st_r  <= cmd.res_st;
      res_hit_r <= cmd.res_hit;
      case (cmd.pos_sel)
        skl_pkg::POS_IDX:  res_pos_r <= idx_r;
        skl_pkg::POS_IDX1: res_pos_r <= IW'(idx_r + IW'(1));
        default:           res_pos_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_st_r;
      out_found_r  <= res_hit_r;
      out_pos_r    <= skl_pkg::POS_W'(res_pos_r);
      out_cnt_r    <= skl_pkg::CNT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("count above depth");
  a_no_full_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.cnt_full) else $error("insert into full list");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("result not presented");
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ram_we && cmd.wsel == skl_pkg::W_DATA_DOWN) |-> idx_r != '0)
    else $error("shift down below entry zero");

endmodule

### design/sorted_key_list.sv
// ----------------------------------------------------------------------------
// sorted_key_list
// Bounded ascending list of signed keys with insert, remove, search, clear.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and yields one result. Keys live in a
// RAM with registered read; every scan or shift step is a read followed by a
// compare/write, so the time per command is set by that RAM port. Clear,
// full insert and empty remove/search go straight to the result with no scan.
// Insert walks down from the top shifting larger keys up. Search scans from
// the bottom and stops at the first match, first larger key or last entry.
// Remove is the search followed by shifting each entry behind the hole down.
// A new transaction is taken as soon as the previous result sits in the
// output register, even if it has not yet been taken. No clearing pass is
// needed after reset: entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_key_list #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [skl_pkg::CMD_W-1:0]          in_command,
  input  logic signed [skl_pkg::KEY_W-1:0]   in_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [skl_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_found,
  output logic [skl_pkg::POS_W-1:0]          out_position,
  output logic [skl_pkg::CNT_W-1:0]          out_entry_count
);

  skl_pkg::dp_cmd_t  cmd;
  skl_pkg::dp_stat_t stat;

  // sequencer: decides each scan/shift step from datapath status
  skl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // storage, index, count and the output register
  skl_dp #(.DEPTH(DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key          (in_key),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

endmodule
